// ===== sv/hsv_pkg.sv =====
// hsv_pkg: constants, sector codes and the divide-by-255 helper for the
// 8-bit HSV to RGB converter. No dependencies; used by hsv_to_rgb_converter.

package hsv_pkg;

    // Full scale of one channel and its square
    localparam logic [7:0]  FULL_SCALE    = 8'd255;
    localparam logic [15:0] FULL_SCALE_SQ = 16'd65025;

    // Six times the hue is at most 1530: eleven bits
    localparam int unsigned HUE6_W = 11;

    // Sector boundaries on the six-times hue scale
    localparam logic [HUE6_W-1:0] SECT_BASE_1 = 11'd255;
    localparam logic [HUE6_W-1:0] SECT_BASE_2 = 11'd510;
    localparam logic [HUE6_W-1:0] SECT_BASE_3 = 11'd765;
    localparam logic [HUE6_W-1:0] SECT_BASE_4 = 11'd1020;
    localparam logic [HUE6_W-1:0] SECT_BASE_5 = 11'd1275;
    localparam logic [HUE6_W-1:0] SECT_BASE_6 = 11'd1530;

    // ceil(2^32 / 255): exact floor(y / 255) for y below 2^32 / 254
    localparam int unsigned        RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_255   = 25'h101_0102;
    localparam int unsigned        RECIP_SHIFT = 32;

    // Color sectors around the hexcone, in hue order
    typedef enum logic [2:0] {
        SECT_R_TO_Y = 3'd0,
        SECT_Y_TO_G = 3'd1,
        SECT_G_TO_C = 3'd2,
        SECT_C_TO_B = 3'd3,
        SECT_B_TO_M = 3'd4,
        SECT_M_TO_R = 3'd5
    } t_sector;

    // floor(y / 255) for y up to 255*255, by add and shift
    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [16:0] sum;
        sum = 17'(y) + 17'(y[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: 8-bit HSV to 8-bit RGB, six-sector hexcone; depends on hsv_pkg.
// An accepted start moves through stages 1 to 5 in order; o_valid is the stage 5 valid bit.
// Throughput: one item per cycle; the five-stage pipeline never stalls, busy stays low.
// Each stage holds at most one multiplier per data path; the exact divide by
// 65025 is a reciprocal multiply (stage 4) and a shift-add divide by 255 (stage 5).
// Reset (synchronous, active low) clears the stage valid bits only.

module hsv_to_rgb_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_brightness,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    // Stage valid bits
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;

    // Stage 1: sector and position inside it
    hsv_pkg::t_sector r_sect1;
    logic [7:0]       r_rem1, r_sat1, r_val1;
    // Stage 2: products with saturation
    hsv_pkg::t_sector r_sect2;
    logic [15:0]      r_rem_s2, r_irem_s2, r_pn2;
    logic [7:0]       r_val2;
    // Stage 3: scaled numerators and p
    hsv_pkg::t_sector r_sect3;
    logic [23:0]      r_yq3, r_yt3;
    logic [7:0]       r_p3, r_val3;
    // Stage 4: first divide by 255
    hsv_pkg::t_sector r_sect4;
    logic [15:0]      r_zq4, r_zt4;
    logic [7:0]       r_p4, r_val4;
    // Stage 5: output registers
    logic [7:0]       r_red, r_green, r_blue;

    logic                          accept;
    logic [hsv_pkg::HUE6_W-1:0]    hue6;
    logic [hsv_pkg::HUE6_W-1:0]    sect_base;
    logic [hsv_pkg::HUE6_W-1:0]    rem_full;
    hsv_pkg::t_sector              n_sect;
    logic [15:0]                   num_q, num_t;
    logic [48:0]                   prod_q, prod_t;
    logic [7:0]                    q5, t5;
    logic [7:0]                    n_red, n_green, n_blue;

    assign accept = i_start && !o_busy;
    assign o_busy = 1'b0;

    // Split six times the hue into sector and remainder
    assign hue6 = hsv_pkg::HUE6_W'(i_hue) * hsv_pkg::HUE6_W'(6);

    always_comb begin
        priority if (hue6 >= hsv_pkg::SECT_BASE_6) begin
            n_sect    = hsv_pkg::SECT_R_TO_Y;
            sect_base = hsv_pkg::SECT_BASE_6;
        end else if (hue6 >= hsv_pkg::SECT_BASE_5) begin
            n_sect    = hsv_pkg::SECT_M_TO_R;
            sect_base = hsv_pkg::SECT_BASE_5;
        end else if (hue6 >= hsv_pkg::SECT_BASE_4) begin
            n_sect    = hsv_pkg::SECT_B_TO_M;
            sect_base = hsv_pkg::SECT_BASE_4;
        end else if (hue6 >= hsv_pkg::SECT_BASE_3) begin
            n_sect    = hsv_pkg::SECT_C_TO_B;
            sect_base = hsv_pkg::SECT_BASE_3;
        end else if (hue6 >= hsv_pkg::SECT_BASE_2) begin
            n_sect    = hsv_pkg::SECT_G_TO_C;
            sect_base = hsv_pkg::SECT_BASE_2;
        end else if (hue6 >= hsv_pkg::SECT_BASE_1) begin
            n_sect    = hsv_pkg::SECT_Y_TO_G;
            sect_base = hsv_pkg::SECT_BASE_1;
        end else begin
            n_sect    = hsv_pkg::SECT_R_TO_Y;
            sect_base = '0;
        end
    end

    assign rem_full = hue6 - sect_base;

    // Numerators of q and t over 65025
    assign num_q = hsv_pkg::FULL_SCALE_SQ - r_rem_s2;
    assign num_t = hsv_pkg::FULL_SCALE_SQ - r_irem_s2;

    // Reciprocal multiply for the first divide by 255
    assign prod_q = 49'(r_yq3) * 49'(hsv_pkg::RECIP_255);
    assign prod_t = 49'(r_yt3) * 49'(hsv_pkg::RECIP_255);

    // Second divide by 255 completes the divide by 65025
    assign q5 = hsv_pkg::div255(r_zq4);
    assign t5 = hsv_pkg::div255(r_zt4);

    // Route v, p, q and t to the channels by sector
    always_comb begin
        unique case (r_sect4)
            hsv_pkg::SECT_R_TO_Y: begin
                n_red = r_val4; n_green = t5;     n_blue = r_p4;
            end
            hsv_pkg::SECT_Y_TO_G: begin
                n_red = q5;     n_green = r_val4; n_blue = r_p4;
            end
            hsv_pkg::SECT_G_TO_C: begin
                n_red = r_p4;   n_green = r_val4; n_blue = t5;
            end
            hsv_pkg::SECT_C_TO_B: begin
                n_red = r_p4;   n_green = q5;     n_blue = r_val4;
            end
            hsv_pkg::SECT_B_TO_M: begin
                n_red = t5;     n_green = r_p4;   n_blue = r_val4;
            end
            default: begin
                n_red = r_val4; n_green = r_p4;   n_blue = q5;
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            r_vld1 <= accept;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        // stage 1
        r_sect1   <= n_sect;
        r_rem1    <= rem_full[7:0];
        r_sat1    <= i_saturation;
        r_val1    <= i_brightness;
        // stage 2
        r_sect2   <= r_sect1;
        r_rem_s2  <= 16'(r_rem1) * 16'(r_sat1);
        r_irem_s2 <= 16'(hsv_pkg::FULL_SCALE - r_rem1) * 16'(r_sat1);
        r_pn2     <= 16'(r_val1) * 16'(hsv_pkg::FULL_SCALE - r_sat1);
        r_val2    <= r_val1;
        // stage 3
        r_sect3   <= r_sect2;
        r_yq3     <= 24'(r_val2) * 24'(num_q);
        r_yt3     <= 24'(r_val2) * 24'(num_t);
        r_p3      <= hsv_pkg::div255(r_pn2);
        r_val3    <= r_val2;
        // stage 4
        r_sect4   <= r_sect3;
        r_zq4     <= prod_q[hsv_pkg::RECIP_SHIFT +: 16];
        r_zt4     <= prod_t[hsv_pkg::RECIP_SHIFT +: 16];
        r_p4      <= r_p3;
        r_val4    <= r_val3;
        // stage 5
        r_red     <= n_red;
        r_green   <= n_green;
        r_blue    <= n_blue;
    end

    assign o_valid = r_vld5;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // A result strobe only follows an accepted item
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && i_rst_n, 5))
        else $error("result strobe without an item accepted five cycles earlier");

    // Grey input gives equal channels at the brightness level
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_saturation, 5) == 8'd0)) |->
        (o_red == $past(i_brightness, 5) && o_green == o_red && o_blue == o_red))
        else $error("grey item did not give equal channels");

    // The brightness always reaches one channel
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red == $past(i_brightness, 5) || o_green == $past(i_brightness, 5)
                     || o_blue == $past(i_brightness, 5)))
        else $error("no channel carries the brightness level");

endmodule
